// ===== sv/stbp_pkg.sv =====
`timescale 1ns / 1ps

package stbp_pkg;

  // Table geometry and history length.
  localparam int unsigned TABLE_ENTRIES = 65536;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned HIST_W        = 21;
  localparam int unsigned CFG_W         = 5;
  localparam int unsigned WADDR_W       = 30;

  // Reset value of the index width register.
  localparam logic [CFG_W-1:0] INDEX_BITS_RST = CFG_W'(16);

  // Opcodes carried in the input tuser.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [HIST_W-1:0]  hist_t;
  typedef logic [WADDR_W-1:0] waddr_t;
  typedef logic [1:0]         ctr_t;

  // Low bits common to all four hashes: history nibble, line, each hash's own low bits and bank select.
  function automatic logic [10:0] common_low(hist_t h, waddr_t a, logic [2:0] lo);
    common_low = {h[3:0], a[8:7], lo, a[6], a[5]};
  endfunction

  function automatic idx_t hash_bim(hist_t h, waddr_t a);
    logic [2:0] hi;
    logic [2:0] lo;
    hi = {a[11], a[9] ^ a[5], a[10] ^ a[6]};
    lo = {a[4], a[3] ^ a[6], a[2] ^ a[5]};
    hash_bim = {a[15], a[14], hi, common_low(h, a, lo)};
  endfunction

  function automatic idx_t hash_b0(hist_t h, waddr_t a);
    logic [4:0] hi;
    logic [2:0] lo;
    hi = {h[7] ^ h[11], h[8] ^ h[12], h[4] ^ h[5], a[9] ^ h[9], h[10] ^ h[6]};
    lo[2] = a[4] ^ a[9] ^ a[13] ^ a[12] ^ h[11] ^ h[8] ^ a[5];
    lo[1] = a[3] ^ a[11] ^ h[9] ^ h[10] ^ h[12] ^ a[6] ^ a[5];
    lo[0] = a[2] ^ a[14] ^ a[10] ^ h[6] ^ h[4] ^ h[7] ^ a[6];
    hash_b0 = {hi, common_low(h, a, lo)};
  endfunction

  function automatic idx_t hash_b1(hist_t h, waddr_t a);
    logic [4:0] hi;
    logic [2:0] lo;
    hi = {h[19] ^ h[12], h[18] ^ h[11], h[17] ^ h[10], a[16] ^ h[4], h[15] ^ h[20]};
    lo[2] = a[4] ^ a[11] ^ a[14] ^ h[4] ^ h[6] ^ h[9] ^ h[14] ^ h[15] ^ h[16];
    lo[1] = a[3] ^ a[10] ^ a[13] ^ h[5] ^ h[11] ^ h[13] ^ h[18] ^ h[19] ^ h[20] ^ a[5];
    lo[0] = a[2] ^ a[5] ^ a[9] ^ h[4] ^ h[8] ^ h[7] ^ a[10] ^ h[12] ^ h[13] ^ h[14]
            ^ h[17];
    hash_b1 = {hi, common_low(h, a, lo)};
  endfunction

  function automatic idx_t hash_meta(hist_t h, waddr_t a);
    logic [4:0] hi;
    logic [2:0] lo;
    hi = {h[7] ^ h[11], h[8] ^ h[12], h[5] ^ h[13], a[4] ^ h[9], h[9] ^ h[6]};
    lo[2] = a[4] ^ a[10] ^ h[7] ^ h[10] ^ h[14] ^ h[13];
    lo[1] = a[3] ^ a[12] ^ a[14] ^ a[6] ^ h[4] ^ h[6] ^ h[8] ^ h[14];
    lo[0] = a[2] ^ a[9] ^ a[11] ^ a[13] ^ h[5] ^ h[9] ^ h[11] ^ a[12] ^ a[6];
    hash_meta = {hi, common_low(h, a, lo)};
  endfunction

  // Two-bit saturating counter step.
  function automatic ctr_t bump(ctr_t c, logic up);
    if (up) begin
      bump = (c == 2'd3) ? c : c + 2'd1;
    end else begin
      bump = (c == 2'd0) ? c : c - 2'd1;
    end
  endfunction

endpackage

// ===== sv/skewed_tournament_branch_predictor.sv =====
`timescale 1ns / 1ps

// Skewed tournament (2bc-gskew style) direction predictor. Each input word
// carries a lookup or update opcode, a branch address and, for updates, the
// resolved direction; every word returns one prediction word computed before
// any update. After reset the four counter tables are swept to zero, one entry
// of all four per cycle, during which no input word is taken (configuration
// writes are taken as ever). A lookup then passes through accept, table read
// and evaluate (evaluate waits while the last result is still held); an update
// then writes back the four counters one after the other through a single
// saturating-counter unit, and the history shifts with the last write. The
// index width register may be written only while the block is idle.
module skewed_tournament_branch_predictor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: index_bits.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stbp_pkg::CFG_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [39:0]                 s_axis_tdata_i,   // branch_address[31:0], outcome, zero pad
  input  logic                        s_axis_tuser_i,   // opcode
  // Output stream.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o    // prediction, zero pad
);
  import stbp_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  // Write-back steps, one table each.
  localparam logic [1:0] STEP_META = 2'd0;
  localparam logic [1:0] STEP_BIM  = 2'd1;
  localparam logic [1:0] STEP_B0   = 2'd2;
  localparam logic [1:0] STEP_B1   = 2'd3;

  logic [2:0]       state_q, state_d;
  logic [1:0]       step_q, step_d;
  idx_t             clr_q, clr_d;
  logic [CFG_W-1:0] index_bits_q, index_bits_d;
  hist_t            hist_q, hist_d;
  logic             op_q, op_d;
  logic             outc_q, outc_d;
  idx_t             im_q, im_d, ib_q, ib_d, i0_q, i0_d, i1_q, i1_d;
  logic [3:0]       en_q, en_d;       // meta, bim, b0, b1
  logic             dir_m_q, dir_m_d;
  logic             ovalid_q, ovalid_d;
  logic             opred_q, opred_d;

  ctr_t rd_m_q, rd_b_q, rd_0_q, rd_1_q;

  // Index mask from the configured width, saturated at the table size.
  logic [CFG_W-1:0] n_bits;
  idx_t             idx_mask;
  waddr_t           waddr;

  assign n_bits   = (index_bits_q > CFG_W'(IDX_W)) ? CFG_W'(IDX_W) : index_bits_q;
  assign idx_mask = IDX_W'(({{IDX_W{1'b0}}, 1'b1} << n_bits) - 1'b1);
  assign waddr    = s_axis_tdata_i[31:2];

  // Prediction from the registered table reads.
  logic fm, fb, f0, f1, fe, fp, unan, fm2, fp2, eval_go;
  ctr_t cm_new;
  logic [3:0] en_eval;
  logic       dir_m_eval;

  assign fm   = rd_m_q[1];
  assign fb   = rd_b_q[1];
  assign f0   = rd_0_q[1];
  assign f1   = rd_1_q[1];
  assign fe   = (fb & f0) | (fb & f1) | (f0 & f1);
  assign fp   = fm ? fb : fe;
  assign unan = (fb == f0) && (fb == f1);

  assign eval_go = (state_q == S_EVAL) && (!ovalid_q || m_axis_tready_i);

  // Partial-update decision: which counters move, and the chooser direction.
  always_comb begin
    en_eval    = 4'b0000;
    dir_m_eval = fm;
    cm_new     = rd_m_q;
    fm2        = fm;
    fp2        = fp;
    if (fp == outc_q && !unan) begin
      en_eval[0] = (fb != fe);
      dir_m_eval = fm;
      if (fm) begin
        en_eval[1] = 1'b1;
      end else begin
        en_eval[1] = (fb == outc_q);
        en_eval[2] = (f0 == outc_q);
        en_eval[3] = (f1 == outc_q);
      end
    end else if (fp != outc_q) begin
      en_eval[3:1] = 3'b111;
      if (fb != fe) begin
        en_eval[0] = 1'b1;
        dir_m_eval = (fb == outc_q);
        cm_new     = bump(rd_m_q, dir_m_eval);
        fm2        = cm_new[1];
        fp2        = fm2 ? fb : fe;
        // Prediction recovered after the chooser moved: only its side trains.
        if (fp2 == outc_q && fm2) begin
          en_eval[3:2] = 2'b00;
        end
      end
    end
  end

  // Shared saturating-counter unit for the write-back steps.
  ctr_t bump_in, bump_out;
  logic bump_up;

  always_comb begin
    case (step_q)
      STEP_META: begin
        bump_in = rd_m_q;
        bump_up = dir_m_q;
      end
      STEP_BIM: begin
        bump_in = rd_b_q;
        bump_up = outc_q;
      end
      STEP_B0: begin
        bump_in = rd_0_q;
        bump_up = outc_q;
      end
      STEP_B1: begin
        bump_in = rd_1_q;
        bump_up = outc_q;
      end
      default: begin
        bump_in = rd_m_q;
        bump_up = dir_m_q;
      end
    endcase
  end
  assign bump_out = bump(bump_in, bump_up);

  // Memory write controls: the clearing sweep writes all four at once.
  logic clearing, writing;
  logic we_m, we_b, we_0, we_1;
  idx_t wa_m, wa_b, wa_0, wa_1;
  ctr_t wdata;

  assign clearing = (state_q == S_CLEAR);
  assign writing  = (state_q == S_WRITE);
  assign we_m  = clearing || (writing && step_q == STEP_META && en_q[0]);
  assign we_b  = clearing || (writing && step_q == STEP_BIM  && en_q[1]);
  assign we_0  = clearing || (writing && step_q == STEP_B0   && en_q[2]);
  assign we_1  = clearing || (writing && step_q == STEP_B1   && en_q[3]);
  assign wa_m  = clearing ? clr_q : im_q;
  assign wa_b  = clearing ? clr_q : ib_q;
  assign wa_0  = clearing ? clr_q : i0_q;
  assign wa_1  = clearing ? clr_q : i1_q;
  assign wdata = clearing ? 2'd0 : bump_out;

  // Counter tables.
  ctr_t mem_m [TABLE_ENTRIES];
  ctr_t mem_b [TABLE_ENTRIES];
  ctr_t mem_0 [TABLE_ENTRIES];
  ctr_t mem_1 [TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_m) begin
      mem_m[wa_m] <= wdata;
    end
    rd_m_q <= mem_m[im_q];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wa_b] <= wdata;
    end
    rd_b_q <= mem_b[ib_q];
  end

  always_ff @(posedge clk_i) begin
    if (we_0) begin
      mem_0[wa_0] <= wdata;
    end
    rd_0_q <= mem_0[i0_q];
  end

  always_ff @(posedge clk_i) begin
    if (we_1) begin
      mem_1[wa_1] <= wdata;
    end
    rd_1_q <= mem_1[i1_q];
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    clr_d        = clr_q;
    index_bits_d = index_bits_q;
    hist_d       = hist_q;
    op_d         = op_q;
    outc_d       = outc_q;
    im_d         = im_q;
    ib_d         = ib_q;
    i0_d         = i0_q;
    i1_d         = i1_q;
    en_d         = en_q;
    dir_m_d      = dir_m_q;
    ovalid_d     = ovalid_q;
    opred_d      = opred_q;

    if (cfg_valid_i) begin
      index_bits_d = cfg_data_i;
    end

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {IDX_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = s_axis_tuser_i;
          outc_d  = s_axis_tdata_i[32];
          im_d    = hash_meta(hist_q, waddr) & idx_mask;
          ib_d    = hash_bim(hist_q, waddr) & idx_mask;
          i0_d    = hash_b0(hist_q, waddr) & idx_mask;
          i1_d    = hash_b1(hist_q, waddr) & idx_mask;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) begin
          ovalid_d = 1'b1;
          opred_d  = fp;
          en_d     = en_eval;
          dir_m_d  = dir_m_eval;
          step_d   = STEP_META;
          state_d  = (op_q == OP_UPDATE) ? S_WRITE : S_IDLE;
        end
      end
      S_WRITE: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_B1) begin
          hist_d  = {hist_q[HIST_W-2:0], outc_q};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      step_q       <= STEP_META;
      clr_q        <= '0;
      index_bits_q <= INDEX_BITS_RST;
      hist_q       <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      clr_q        <= clr_d;
      index_bits_q <= index_bits_d;
      hist_q       <= hist_d;
      ovalid_q     <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    outc_q  <= outc_d;
    im_q    <= im_d;
    ib_q    <= ib_d;
    i0_q    <= i0_d;
    i1_q    <= i1_d;
    en_q    <= en_d;
    dir_m_q <= dir_m_d;
    opred_q <= opred_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {7'd0, opred_q};

  // No input word is taken during the clearing sweep.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("input accepted during table clearing");

  // Tables are written only by the sweep or the write-back steps.
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_m || we_b || we_0 || we_1) |-> (state_q == S_CLEAR || state_q == S_WRITE))
    else $error("table written outside sweep or write-back");

  // History moves only at the end of an update's write-back.
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hist_q) |-> $past(state_q == S_WRITE && step_q == STEP_B1))
    else $error("history changed outside update write-back");

  // A new result appears only from the evaluation step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_EVAL))
    else $error("result raised outside evaluation");

endmodule

// ===== test/tb_skewed_tournament_branch_predictor.sv =====
`timescale 1ns / 1ps

module tb_skewed_tournament_branch_predictor;
  import stbp_pkg::*;

  // A quiet stretch must cover the table sweep after reset plus the slowest word.
  localparam int unsigned QUIET_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_WORDS   = 150;
  localparam int unsigned POOL_SIZE     = 8;

  // Outcome patterns that the branches of one phase follow.
  typedef enum int {ALWAYS_TAKEN, NEVER_TAKEN, ALTERNATING, LOOP_EXIT, COIN_FLIP} pattern_e;

  // Mirror of the predictor tables and history, plus the queue of pending predictions.
  class stbp_scoreboard;
    bit [1:0]  bim_ctr[TABLE_ENTRIES];
    bit [1:0]  bank0_ctr[TABLE_ENTRIES];
    bit [1:0]  bank1_ctr[TABLE_ENTRIES];
    bit [1:0]  meta_ctr[TABLE_ENTRIES];
    bit [20:0] history;
    bit [4:0]  width;
    bit        pending_pred_q[$];
    int        errors;
    int        checked;
    int        lookups;
    int        updates;

    function new();
      foreach (bim_ctr[i]) begin
        bim_ctr[i]   = '0;
        bank0_ctr[i] = '0;
        bank1_ctr[i] = '0;
        meta_ctr[i]  = '0;
      end
      history = '0;
      width   = INDEX_BITS_RST;
      errors  = 0;
      checked = 0;
      lookups = 0;
      updates = 0;
    endfunction

    function void set_width(bit [4:0] w);
      width = w;
    endfunction

    function int pending();
      return pending_pred_q.size();
    endfunction

    // Low eleven index bits: history nibble, cache line, hashed low bits, bank.
    function bit [10:0] shared_low(bit [20:0] h, bit [29:0] a, bit [2:0] lo);
      return {h[3:0], a[8:7], lo, a[6], a[5]};
    endfunction

    function bit [15:0] idx_bimodal(bit [20:0] h, bit [29:0] a);
      bit [2:0] hi;
      bit [2:0] lo;
      hi = {a[11], a[9] ^ a[5], a[10] ^ a[6]};
      lo = {a[4], a[3] ^ a[6], a[2] ^ a[5]};
      return {a[15:14], hi, shared_low(h, a, lo)};
    endfunction

    function bit [15:0] idx_bank0(bit [20:0] h, bit [29:0] a);
      bit [4:0] hi;
      bit [2:0] lo;
      hi    = {h[7] ^ h[11], h[8] ^ h[12], h[4] ^ h[5], a[9] ^ h[9], h[10] ^ h[6]};
      lo[2] = a[4] ^ a[9] ^ a[13] ^ a[12] ^ h[11] ^ h[8] ^ a[5];
      lo[1] = a[3] ^ a[11] ^ h[9] ^ h[10] ^ h[12] ^ a[6] ^ a[5];
      lo[0] = a[2] ^ a[14] ^ a[10] ^ h[6] ^ h[4] ^ h[7] ^ a[6];
      return {hi, shared_low(h, a, lo)};
    endfunction

    function bit [15:0] idx_bank1(bit [20:0] h, bit [29:0] a);
      bit [4:0] hi;
      bit [2:0] lo;
      hi    = {h[19] ^ h[12], h[18] ^ h[11], h[17] ^ h[10], a[16] ^ h[4], h[15] ^ h[20]};
      lo[2] = a[4] ^ a[11] ^ a[14] ^ h[4] ^ h[6] ^ h[9] ^ h[14] ^ h[15] ^ h[16];
      lo[1] = a[3] ^ a[10] ^ a[13] ^ h[5] ^ h[11] ^ h[13] ^ h[18] ^ h[19] ^ h[20] ^ a[5];
      lo[0] = a[2] ^ a[5] ^ a[9] ^ h[4] ^ h[8] ^ h[7] ^ a[10] ^ h[12] ^ h[13] ^ h[14]
              ^ h[17];
      return {hi, shared_low(h, a, lo)};
    endfunction

    function bit [15:0] idx_chooser(bit [20:0] h, bit [29:0] a);
      bit [4:0] hi;
      bit [2:0] lo;
      hi    = {h[7] ^ h[11], h[8] ^ h[12], h[5] ^ h[13], a[4] ^ h[9], h[9] ^ h[6]};
      lo[2] = a[4] ^ a[10] ^ h[7] ^ h[10] ^ h[14] ^ h[13];
      lo[1] = a[3] ^ a[12] ^ a[14] ^ a[6] ^ h[4] ^ h[6] ^ h[8] ^ h[14];
      lo[0] = a[2] ^ a[9] ^ a[11] ^ a[13] ^ h[5] ^ h[9] ^ h[11] ^ a[12] ^ a[6];
      return {hi, shared_low(h, a, lo)};
    endfunction

    // Widths above 16 behave as 16; a 16-bit index never runs past the table.
    function bit [15:0] masked(bit [15:0] raw);
      int unsigned n;
      bit [31:0]   mask;
      n    = (width > 5'd16) ? 16 : width;
      mask = (32'd1 << n) - 32'd1;
      return raw & mask[15:0];
    endfunction

    function bit [1:0] saturate(bit [1:0] c, bit up);
      if (up) begin
        return (c == 2'd3) ? c : c + 2'd1;
      end
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // Predict for one accepted word, then train the tables on an update.
    function void note_word(bit op, bit [31:0] addr, bit dir);
      bit [29:0] a;
      bit [15:0] im, ib, i0, i1;
      bit        fm, fb, f0, f1, fe, fp;
      bit        unanimous;
      bit        train_all;
      a  = addr[31:2];
      im = masked(idx_chooser(history, a));
      ib = masked(idx_bimodal(history, a));
      i0 = masked(idx_bank0(history, a));
      i1 = masked(idx_bank1(history, a));
      fm = meta_ctr[im][1];
      fb = bim_ctr[ib][1];
      f0 = bank0_ctr[i0][1];
      f1 = bank1_ctr[i1][1];
      fe = (int'(fb) + int'(f0) + int'(f1)) >= 2;
      fp = fm ? fb : fe;
      pending_pred_q.push_back(fp);
      if (op == OP_LOOKUP) begin
        lookups++;
        return;
      end
      updates++;
      unanimous = (fb == f0) && (fb == f1);
      if (fp == dir && !unanimous) begin
        // Right but split: reinforce the chooser if the sides disagree, and the right banks of the chosen side.
        if (fb != fe) meta_ctr[im] = saturate(meta_ctr[im], fm);
        if (fm) begin
          bim_ctr[ib] = saturate(bim_ctr[ib], dir);
        end else begin
          if (fb == dir) bim_ctr[ib] = saturate(bim_ctr[ib], dir);
          if (f0 == dir) bank0_ctr[i0] = saturate(bank0_ctr[i0], dir);
          if (f1 == dir) bank1_ctr[i1] = saturate(bank1_ctr[i1], dir);
        end
      end else if (fp != dir) begin
        // Wrong: retrain the chooser first, then whichever banks now apply.
        train_all = 1'b1;
        if (fb != fe) begin
          meta_ctr[im] = saturate(meta_ctr[im], fb == dir);
          fm = meta_ctr[im][1];
          fp = fm ? fb : fe;
          if (fp == dir) begin
            train_all   = 1'b0;
            bim_ctr[ib] = saturate(bim_ctr[ib], dir);
            if (!fm) begin
              bank0_ctr[i0] = saturate(bank0_ctr[i0], dir);
              bank1_ctr[i1] = saturate(bank1_ctr[i1], dir);
            end
          end
        end
        if (train_all) begin
          bim_ctr[ib]   = saturate(bim_ctr[ib], dir);
          bank0_ctr[i0] = saturate(bank0_ctr[i0], dir);
          bank1_ctr[i1] = saturate(bank1_ctr[i1], dir);
        end
      end
      history = {history[19:0], dir};
    endfunction

    // Compare one delivered prediction with the oldest pending one.
    function void check_word(logic got);
      bit want;
      if (pending_pred_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("prediction word %b arrived with none pending", got);
        return;
      end
      want = pending_pred_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("prediction %0d: expected %b, got %b", checked, want, got);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [39:0]          s_axis_tdata_i;  // branch_address[31:0], outcome, zero pad
  logic                 s_axis_tuser_i;  // opcode
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [7:0]           m_axis_tdata_o;  // prediction, zero pad

  stbp_scoreboard sb;
  int             idle_pct;
  int             stall_left;
  int unsigned    quiet_cycles;
  int             widths_seen;

  skewed_tournament_branch_predictor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: ready drops for random bursts while idling is enabled.
  initial begin
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          stall_left = $urandom_range(1, 10);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_word(m_axis_tdata_o[0]);
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("tb_skewed_tournament_branch_predictor: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_width(bit [4:0] w);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_width(w);
    widths_seen++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one word, with an optional gap before it, and wait for acceptance.
  task automatic send_word(bit op, bit [31:0] addr, bit dir);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 10);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {7'b0, dir, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(op, addr, dir);
  endtask

  // Wait for every prediction, then let any trailing write-back finish.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Extremes of the fields, lookups with the outcome bit set, and repeated branches.
  task automatic send_directed();
    send_word(OP_LOOKUP, 32'h0000_0000, 1'b0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_UPDATE, 32'h0000_0000, 1'b0);
    send_word(OP_UPDATE, 32'h0000_0003, 1'b1);
    send_word(OP_LOOKUP, 32'h8000_0000, 1'b1);
    send_word(OP_UPDATE, 32'h7FFF_FFFC, 1'b0);
    repeat (6) send_word(OP_UPDATE, 32'h0000_1000, 1'b1);
    send_word(OP_LOOKUP, 32'h0000_1000, 1'b0);
    repeat (3) send_word(OP_UPDATE, 32'h0000_1000, 1'b0);
    send_word(OP_UPDATE, 32'hAAAA_AAAA, 1'b1);
    send_word(OP_UPDATE, 32'h5555_5555, 1'b0);
    send_word(OP_LOOKUP, 32'hAAAA_AAAA, 1'b0);
  endtask

  // One phase: set the width, then mostly patterned branches with some noise.
  task automatic run_phase(bit [4:0] w, int words, bit directed);
    bit [31:0] pool[POOL_SIZE];
    pattern_e  shape[POOL_SIZE];
    int        seen[POOL_SIZE];
    int        k;
    int        roll;
    bit        dir;
    write_width(w);
    if (directed) send_directed();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i]  = $urandom;
      shape[i] = pattern_e'($urandom_range(0, 4));
      seen[i]  = 0;
    end
    repeat (words) begin
      k    = $urandom_range(0, POOL_SIZE - 1);
      roll = $urandom_range(0, 99);
      case (shape[k])
        ALWAYS_TAKEN: dir = 1'b1;
        NEVER_TAKEN:  dir = 1'b0;
        ALTERNATING:  dir = seen[k][0];
        LOOP_EXIT:    dir = (seen[k] % 8) != 7;
        default:      dir = 1'($urandom_range(0, 1));
      endcase
      if (roll < 70) begin
        send_word(OP_UPDATE, pool[k], dir);
        seen[k]++;
      end else if (roll < 85) begin
        send_word(OP_LOOKUP, pool[k], 1'($urandom_range(0, 1)));
      end else begin
        send_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  initial begin
    bit [4:0] plan[10];
    int       pct_pick[3];
    sb              = new();
    idle_pct        = 0;
    quiet_cycles    = 0;
    widths_seen     = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_LOOKUP;
    plan     = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd17, 5'd2, 5'd0, 5'd10, 5'd16};
    plan[7]  = 5'($urandom_range(3, 15));
    pct_pick = '{0, 15, 40};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // All phases but the last pick a random idling rate, possibly none; the last runs flat out.
    for (int p = 0; p < 10; p++) begin
      idle_pct = (p == 9) ? 0 : pct_pick[$urandom_range(0, 2)];
      run_phase(plan[p], PHASE_WORDS, p == 0);
    end

    $display("covered %0d lookups and %0d updates over %0d index width settings,",
             sb.lookups, sb.updates, widths_seen);
    $display("with %0d predictions checked against the mirrored tables", sb.checked);
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("tb_skewed_tournament_branch_predictor: done, clean");
    end else begin
      $display("tb_skewed_tournament_branch_predictor: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/stbp_pkg.sv
sv/skewed_tournament_branch_predictor.sv
test/tb_skewed_tournament_branch_predictor.sv
